@@ rtl/mbps_pkg.sv @@
`default_nettype none

package mbps_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_PATTERN_LOWER = 3'd0,
        CFG_PATTERN_UPPER = 3'd1,
        CFG_CARE_MASK     = 3'd2,
        CFG_PATTERN_LEN   = 3'd3,
        CFG_BASE_ADDRESS  = 3'd4
    } cfg_index_t;

    // per-beat control shared by every cell of the window chain
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // compare setup for one cell: pattern byte lined up with its tap distance
    typedef struct packed {
        logic       active;
        logic       care;
        logic [7:0] pattern;
    } cell_setup_t;

endpackage

`default_nettype wire

@@ rtl/mbps_cell.sv @@
`default_nettype none

module mbps_cell
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [7:0]           tap_in,
    input  wire mbps_pkg::cell_ctrl_t ctrl,
    input  wire mbps_pkg::cell_setup_t setup,
    output logic [7:0]                tap_out,
    output logic                      miss
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // window byte: cleared at section end, takes the neighbour's byte on shift
    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = 8'd0;
        end
        else if (ctrl.shift)
        begin
            byte_next = tap_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign tap_out = byte_reg;

    // mismatch on a cared-for position inside the pattern
    assign miss = setup.active && setup.care && (tap_in != setup.pattern);

endmodule

`default_nettype wire

@@ rtl/masked_byte_pattern_scan_core.sv @@
// Masked byte pattern scan over one data section.
// Input channel (in_valid/in_ready): one beat per section byte, data_byte with
// last_byte set on the final byte of the section. Output channel
// (out_valid/out_ready): at most one beat per section: found=1 with the match
// address when the pattern first matches, or found=0 on the last byte if no
// match occurred. Later bytes of a section after a match give no beat.
// Configuration: cfg_we/cfg_index/cfg_data, one register per write, no wait.
// Throughput: one byte per cycle unless a pending result holds in_ready low;
// the window is a chain of byte cells that shift each accepted byte before a
// match, clear on the last byte and compare in parallel with the pattern.
// A result is registered as its byte is accepted and held there until taken.
// While the receiver stalls with a result pending, in_ready is low; it rises
// again in the cycle the result is taken, so no bubble is lost.
// Reset clears the window, byte count and match flag, sets care mask to all
// ones and pattern length to one, and empties the output register.
`default_nettype none

module masked_byte_pattern_scan_core
#(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int OFFSET_BITS       = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             found,
    output logic [63:0]      match_address,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);

    // configuration registers
    logic [63:0] pattern_lower_reg;
    logic [63:0] pattern_upper_reg;
    logic [15:0] care_mask_reg;
    logic [4:0]  pattern_length_reg;
    logic [63:0] base_address_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_lower_reg  <= 64'd0;
            pattern_upper_reg  <= 64'd0;
            care_mask_reg      <= 16'hFFFF;
            pattern_length_reg <= 5'd1;
            base_address_reg   <= 64'd0;
        end
        else if (cfg_we)
        begin
            unique case (mbps_pkg::cfg_index_t'(cfg_index))
                mbps_pkg::CFG_PATTERN_LOWER: pattern_lower_reg  <= cfg_data;
                mbps_pkg::CFG_PATTERN_UPPER: pattern_upper_reg  <= cfg_data;
                mbps_pkg::CFG_CARE_MASK:     care_mask_reg      <= cfg_data[15:0];
                mbps_pkg::CFG_PATTERN_LEN:   pattern_length_reg <= cfg_data[4:0];
                mbps_pkg::CFG_BASE_ADDRESS:  base_address_reg   <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // effective pattern length, clamped to one .. MAX_PATTERN_BYTES
    logic [7:0]    plen_ext;
    logic [LW-1:0] len_eff;

    always_comb
    begin
        plen_ext = {3'd0, pattern_length_reg};
        if (plen_ext == 8'd0)
        begin
            len_eff = LW'(1);
        end
        else if (plen_ext > 8'(MAX_PATTERN_BYTES))
        begin
            len_eff = LW'(MAX_PATTERN_BYTES);
        end
        else
        begin
            len_eff = LW'(plen_ext);
        end
    end

    // scan state and handshake
    logic                   match_reported_reg;
    logic                   match_reported_next;
    logic [OFFSET_BITS-1:0] bytes_seen_reg;
    logic [OFFSET_BITS-1:0] bytes_seen_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   found_reg;
    logic                   found_next;
    logic [63:0]            match_address_reg;
    logic [63:0]            match_address_next;

    logic                 accept;
    logic                 scanning;
    mbps_pkg::cell_ctrl_t ctrl;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign scanning = accept && !match_reported_reg;

    assign ctrl.shift = scanning && !last_byte;
    assign ctrl.clear = accept && last_byte;

    // window chain: cell d compares the byte at distance d from the newest
    logic [7:0]                  tap   [MAX_PATTERN_BYTES+1];
    logic [MAX_PATTERN_BYTES-1:0] miss;
    mbps_pkg::cell_setup_t       setup [MAX_PATTERN_BYTES];
    logic [127:0]                pattern_all;

    assign tap[0]      = data_byte;
    assign pattern_all = {pattern_upper_reg, pattern_lower_reg};

    for (genvar d = 0; d < MAX_PATTERN_BYTES; d++)
    begin : g_cell
        logic [7:0] j;

        // pattern position lined up with this tap distance
        always_comb
        begin
            j                  = 8'(len_eff) - 8'd1 - 8'(d);
            setup[d].active    = (8'(d) < 8'(len_eff));
            setup[d].care      = 1'b0;
            setup[d].pattern   = 8'd0;
            if (j == 8'd0)
            begin
                setup[d].care    = 1'b1;
                setup[d].pattern = pattern_all[7:0];
            end
            else if (j < 8'd16)
            begin
                setup[d].care    = care_mask_reg[j[3:0]];
                setup[d].pattern = pattern_all[{j[3:0], 3'b000} +: 8];
            end
        end

        mbps_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .tap_in  (tap[d]),
            .ctrl    (ctrl),
            .setup   (setup[d]),
            .tap_out (tap[d+1]),
            .miss    (miss[d])
        );
    end

    // saturating byte count and match decision
    logic [OFFSET_BITS-1:0] count_after;
    logic [OFFSET_BITS-1:0] len_wide;
    logic                   hit;

    assign count_after = (&bytes_seen_reg) ? bytes_seen_reg
                                           : bytes_seen_reg + OFFSET_BITS'(1);
    assign len_wide    = OFFSET_BITS'(len_eff);
    assign hit         = (count_after >= len_wide) && (miss == '0);

    // next state and result register
    always_comb
    begin
        match_reported_next = match_reported_reg;
        bytes_seen_next     = bytes_seen_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        found_next          = found_reg;
        match_address_next  = match_address_reg;

        if (scanning && (hit || last_byte))
        begin
            out_valid_next     = 1'b1;
            found_next         = hit;
            match_address_next = hit ? base_address_reg + 64'(count_after - len_wide)
                                     : 64'd0;
        end

        if (accept && last_byte)
        begin
            match_reported_next = 1'b0;
            bytes_seen_next     = '0;
        end
        else if (scanning)
        begin
            match_reported_next = hit;
            bytes_seen_next     = count_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reported_reg <= 1'b0;
            bytes_seen_reg     <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            match_reported_reg <= match_reported_next;
            bytes_seen_reg     <= bytes_seen_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg         <= found_next;
        match_address_reg <= match_address_next;
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_address = match_address_reg;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// one scan result as seen on the output channel
typedef struct {
    logic        found;
    logic [63:0] address;
} scan_find_t;

// tracks pattern, care mask and window state, and the finds still owed by the block
class scan_scoreboard;
    logic [127:0] pattern;
    logic [15:0]  care;
    logic [4:0]   length_reg;
    logic [63:0]  base;
    logic [7:0]   window [15];
    logic [31:0]  seen;
    bit           reported;
    scan_find_t   expected_finds [$];
    int           errors;

    function new();
        pattern    = '0;
        care       = 16'hFFFF;
        length_reg = 5'd1;
        base       = '0;
        errors     = 0;
        restart();
    endfunction

    function void restart();
        foreach (window[i])
            window[i] = 8'h00;
        seen     = '0;
        reported = 0;
    endfunction

    function void write_reg(mbps_pkg::cfg_index_t idx, logic [63:0] value);
        case (idx)
            mbps_pkg::CFG_PATTERN_LOWER: pattern[63:0]   = value;
            mbps_pkg::CFG_PATTERN_UPPER: pattern[127:64] = value;
            mbps_pkg::CFG_CARE_MASK:     care            = value[15:0];
            mbps_pkg::CFG_PATTERN_LEN:   length_reg      = value[4:0];
            mbps_pkg::CFG_BASE_ADDRESS:  base            = value;
            default: ;
        endcase
    endfunction

    // pattern positions in use, zero read as one and capped at sixteen
    function int span();
        int len;
        len = int'(length_reg);
        if (len < 1)
            len = 1;
        if (len > 16)
            len = 16;
        return len;
    endfunction

    function logic [7:0] pattern_byte(int j);
        return pattern[8*j +: 8];
    endfunction

    // byte 0 is always compared
    function bit cares(int j);
        return (j == 0) || care[j];
    endfunction

    function int pending();
        return expected_finds.size();
    endfunction

    // advance the scan by one byte
    function void note_byte(logic [7:0] b, logic last);
        int          len;
        int          j;
        int          d;
        logic [31:0] count_after;
        logic [7:0]  actual;
        bit          hit;
        scan_find_t  f;
        len = span();
        // rest of a section after its match
        if (reported)
        begin
            if (last)
                restart();
            return;
        end
        count_after = (seen == '1) ? seen : seen + 32'd1;
        hit = 0;
        if (count_after >= 32'(len))
        begin
            hit = 1;
            for (j = 0; j < len; j++)
            begin
                d = len - 1 - j;
                actual = (d == 0) ? b : window[d-1];
                if (cares(j) && actual != pattern_byte(j))
                    hit = 0;
            end
        end
        if (hit)
        begin
            f.found   = 1'b1;
            f.address = base + 64'(count_after - 32'(len));
            expected_finds.push_back(f);
            reported = 1;
        end
        else if (last)
        begin
            f.found   = 1'b0;
            f.address = '0;
            expected_finds.push_back(f);
        end
        if (last)
        begin
            restart();
            return;
        end
        for (j = 14; j > 0; j--)
            window[j] = window[j-1];
        window[0] = b;
        seen = count_after;
    endfunction

    task report(string msg);
        if (errors < 60)
            $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_find(logic f, logic [63:0] a);
        scan_find_t want;
        if (expected_finds.size() == 0)
        begin
            report($sformatf("unexpected beat found=%0b address=%h", f, a));
            return;
        end
        want = expected_finds.pop_front();
        if (f !== want.found)
            report($sformatf("found %0b, wanted %0b", f, want.found));
        if (a !== want.address)
            report($sformatf("address %h, wanted %h", a, want.address));
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 300000;
    localparam int PHASE_BYTES  = 136;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic        found;
    logic [63:0] match_address;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    scan_scoreboard sb;
    int gap_pct;
    int stall_pct;
    int hold_cycles;
    int sent_bytes;
    int cycle_count;

    masked_byte_pattern_scan_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .match_address (match_address),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // receiver: long hold-off when asked, otherwise random stalls
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_find(found, match_address);
    end

    task automatic set_idling(int mode);
        case (mode)
            0:
            begin
                gap_pct = 0;  stall_pct = 0;
            end
            1:
            begin
                gap_pct = 48; stall_pct = 0;
            end
            2:
            begin
                gap_pct = 0;  stall_pct = 48;
            end
            default:
            begin
                gap_pct = 34; stall_pct = 34;
            end
        endcase
    endtask

    // one byte beat, held until accepted
    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b, last);
        sent_bytes++;
    endtask

    // stop offering and wait for every owed result
    task automatic wait_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    // idle block: results drained plus the output register's latency
    task automatic settle();
        wait_results();
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(mbps_pkg::cfg_index_t idx, logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_setup(logic [63:0] lo, logic [63:0] hi, logic [15:0] care_bits,
                              logic [4:0] len, logic [63:0] base_addr);
        write_reg(mbps_pkg::CFG_PATTERN_LOWER, lo);
        write_reg(mbps_pkg::CFG_PATTERN_UPPER, hi);
        write_reg(mbps_pkg::CFG_CARE_MASK, 64'(care_bits));
        write_reg(mbps_pkg::CFG_PATTERN_LEN, 64'(len));
        write_reg(mbps_pkg::CFG_BASE_ADDRESS, base_addr);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // filler that often repeats a pattern byte, to provoke near misses
    function automatic logic [7:0] near_byte(int len);
        if ($urandom_range(1))
            return 8'($urandom);
        return sb.pattern_byte($urandom_range(len - 1, 0));
    endfunction

    function automatic logic [7:0] occurrence_byte(int j);
        if (sb.cares(j))
            return sb.pattern_byte(j);
        return 8'($urandom);
    endfunction

    // one section: mostly a planted occurrence among filler, else noise or a broken one
    task automatic run_section();
        logic [7:0] seq [$];
        int len;
        int n;
        int cut;
        int j;
        int spoil;
        bit ends_early;
        len = sb.span();
        ends_early = 0;
        if ($urandom_range(99) < 15)
        begin
            n = $urandom_range(24, 1);
            repeat (n) seq.push_back(8'($urandom));
        end
        else
        begin
            n = $urandom_range(12, 0);
            repeat (n) seq.push_back(near_byte(len));
            // false start: the pattern's head alone
            if ($urandom_range(3) == 0)
            begin
                cut = $urandom_range(len - 1, 0);
                for (j = 0; j < cut; j++)
                    seq.push_back(occurrence_byte(j));
            end
            cut = ($urandom_range(99) < 20) ? $urandom_range(len - 1, 0) : len;
            spoil = ($urandom_range(99) < 10) ? $urandom_range(len - 1, 0) : -1;
            for (j = 0; j < cut; j++)
            begin
                if (j == spoil)
                    seq.push_back(occurrence_byte(j) ^ (8'h01 << $urandom_range(7)));
                else
                    seq.push_back(occurrence_byte(j));
            end
            // truncated occurrence running into the section end
            if (cut < len && $urandom_range(1))
                ends_early = 1;
            if (!ends_early)
            begin
                n = $urandom_range(10, 0);
                repeat (n) seq.push_back(near_byte(len));
            end
        end
        if (seq.size() == 0)
            seq.push_back(8'($urandom));
        foreach (seq[i])
        begin
            send_byte(seq[i], i == seq.size() - 1);
            if (i != seq.size() - 1 && $urandom_range(99) < 3)
                wait_results();
        end
    endtask

    // phase setups, extremes among them
    task automatic phase_setup(int p);
        case (p)
            0: load_setup(rand64(), rand64(), 16'hFFFF, 5'd16, rand64());
            1: load_setup('1, '0, 16'h0000, 5'd31, '1);
            2: load_setup(rand64(), rand64(), 16'($urandom), 5'd0, '0);
            3: load_setup(rand64(), rand64(), 16'($urandom), 5'($urandom_range(15, 2)), rand64());
            4: load_setup('0, '1, 16'hFFFF, 5'd1, '1);
            5: load_setup(rand64(), rand64(), 16'($urandom), 5'($urandom_range(16, 1)),
                          rand64());
            6: load_setup({8{8'h5A}}, {8{8'h5A}}, 16'($urandom), 5'd8, rand64());
            default: load_setup(rand64(), rand64(), 16'($urandom), 5'($urandom_range(31)),
                                rand64());
        endcase
    endtask

    // stimulus
    initial
    begin
        sb = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = 8'h00;
        last_byte   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = mbps_pkg::CFG_PATTERN_LOWER;
        cfg_data    = '0;
        gap_pct     = 0;
        stall_pct   = 0;
        hold_cycles = 0;
        sent_bytes  = 0;
        cycle_count = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset setup: single zero byte pattern, then the tail of the section is skipped
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAB, 1'b1);
        send_byte(8'hFF, 1'b1);

        // care bit 0 clear still compares byte 0; base at all ones wraps
        settle();
        load_setup(64'h0000_0000_0000_00A5, '0, 16'h0000, 5'd4, '1);
        // section shorter than the pattern
        send_byte(8'hA5, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // match ending on the last byte
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b1);
        // length change in the middle of a section
        send_byte(8'h11, 1'b0);
        send_byte(8'hA5, 1'b0);
        settle();
        write_reg(mbps_pkg::CFG_PATTERN_LEN, 64'd2);
        send_byte(8'h33, 1'b1);
        // length zero acts as one
        settle();
        write_reg(mbps_pkg::CFG_PATTERN_LEN, 64'd0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'hA5, 1'b1);

        // receiver holds off while short sections keep coming: input must back up
        settle();
        load_setup(rand64(), rand64(), 16'($urandom), 5'd1, rand64());
        hold_cycles = 300;
        repeat (40)
        begin
            if ($urandom_range(1))
                send_byte(8'($urandom), 1'b0);
            send_byte(8'($urandom), 1'b1);
        end

        // random phases
        for (int p = 0; p < 8; p++)
        begin
            settle();
            set_idling(p % 4);
            phase_setup(p);
            while (sent_bytes < (p + 1) * PHASE_BYTES + 60)
                run_section();
        end

        wait_results();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

@@ masked_byte_pattern_scan_core.f @@
rtl/mbps_pkg.sv
rtl/mbps_cell.sv
rtl/masked_byte_pattern_scan_core.sv
verif/tb.sv
